### src/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg
// Shared types and constants for the cursor text buffer: capacity, field
// widths, request and status codes, and the beat payload structs.
// ----------------------------------------------------------------------------
package ctb_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = ADDR_W + 1;

  localparam int REQ_W  = 3;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 8;
  localparam int POS_W  = 9;
  localparam int STAT_W = 2;

  localparam logic [REQ_W-1:0] REQ_INSERT   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FORWARD  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_BACKWARD = 3'd3;
  localparam logic [REQ_W-1:0] REQ_START    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_END      = 3'd5;
  localparam logic [REQ_W-1:0] REQ_READ     = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [CHAR_W-1:0] char_in;
    logic [IDX_W-1:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [POS_W-1:0]  text_length;
    logic [CHAR_W-1:0] read_char;
    logic [STAT_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] data;
  } mem_wr_t;

endpackage

### src/ctb_ram.sv
// ----------------------------------------------------------------------------
// ctb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ctb_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/ctb_ctrl.sv
// ----------------------------------------------------------------------------
// ctb_ctrl
// Request sequencer: holds cursor and length, runs the one-entry-per-cycle
// shift loop through the RAM ports, and forms the result beat.
// ----------------------------------------------------------------------------
module ctb_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ctb_pkg::in_item_t               in_item,
  output ctb_pkg::mem_wr_t                mem_wr,
  output logic [ctb_pkg::ADDR_W-1:0]      mem_raddr,
  input  logic [ctb_pkg::CHAR_W-1:0]      mem_rdata,
  output logic                            res_valid,
  input  logic                            res_take,
  output ctb_pkg::out_item_t              res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_PUT_CH,
    S_RD_WAIT,
    S_DONE
  } state_t;

  state_t                        state_r, state_nxt;
  logic [ctb_pkg::CNT_W-1:0]     cur_r, cur_nxt;
  logic [ctb_pkg::CNT_W-1:0]     len_r, len_nxt;
  logic [ctb_pkg::CNT_W-1:0]     rem_r, rem_nxt;
  logic [ctb_pkg::ADDR_W-1:0]    ra_r, ra_nxt;
  logic [ctb_pkg::ADDR_W-1:0]    pa_r, pa_nxt;
  logic                          pend_r, pend_nxt;
  logic [ctb_pkg::CHAR_W-1:0]    ch_r, ch_nxt;
  ctb_pkg::out_item_t            res_r, res_nxt;

  logic                          finish;
  logic [ctb_pkg::CHAR_W-1:0]    rd_v;
  logic [ctb_pkg::STAT_W-1:0]    st_v;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    ra_nxt    = ra_r;
    pa_nxt    = pa_r;
    pend_nxt  = pend_r;
    ch_nxt    = ch_r;
    res_nxt   = res_r;
    mem_wr    = '0;
    mem_raddr = ra_r;
    finish    = 1'b0;
    rd_v      = '0;
    st_v      = ctb_pkg::ST_OK;

    case (state_r)
      S_IDLE: begin
        mem_raddr = ctb_pkg::ADDR_W'(in_item.read_index);
        if (in_valid) begin
          case (in_item.req_type)
            ctb_pkg::REQ_INSERT: begin
              if (len_r >= ctb_pkg::CNT_W'(ctb_pkg::CAPACITY)) begin
                st_v   = ctb_pkg::ST_FULL;
                finish = 1'b1;
              end else begin
                ch_nxt    = in_item.char_in;
                rem_nxt   = len_r - cur_r;
                ra_nxt    = ctb_pkg::ADDR_W'(len_r - 1'b1);
                pend_nxt  = 1'b0;
                state_nxt = S_SHIFT_UP;
              end
            end
            ctb_pkg::REQ_DELETE: begin
              if (cur_r < len_r) begin
                rem_nxt   = len_r - cur_r - 1'b1;
                ra_nxt    = ctb_pkg::ADDR_W'(cur_r + 1'b1);
                pend_nxt  = 1'b0;
                state_nxt = S_SHIFT_DN;
              end else begin
                finish = 1'b1;
              end
            end
            ctb_pkg::REQ_FORWARD: begin
              if (cur_r < len_r) begin
                cur_nxt = cur_r + 1'b1;
              end
              finish = 1'b1;
            end
            ctb_pkg::REQ_BACKWARD: begin
              if (cur_r != '0) begin
                cur_nxt = cur_r - 1'b1;
              end
              finish = 1'b1;
            end
            ctb_pkg::REQ_START: begin
              cur_nxt = '0;
              finish  = 1'b1;
            end
            ctb_pkg::REQ_END: begin
              cur_nxt = len_r;
              finish  = 1'b1;
            end
            ctb_pkg::REQ_READ: begin
              if (ctb_pkg::CNT_W'(in_item.read_index) < len_r) begin
                state_nxt = S_RD_WAIT;
              end else begin
                st_v   = ctb_pkg::ST_RANGE;
                finish = 1'b1;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end

      S_SHIFT_UP: begin
        // write lands one above the entry read last cycle
        if (pend_r) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = pa_r + 1'b1;
          mem_wr.data = mem_rdata;
        end
        if (rem_r != '0) begin
          pend_nxt = 1'b1;
          pa_nxt   = ra_r;
          ra_nxt   = ra_r - 1'b1;
          rem_nxt  = rem_r - 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_PUT_CH;
        end
      end

      S_PUT_CH: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = ctb_pkg::ADDR_W'(cur_r);
        mem_wr.data = ch_r;
        cur_nxt     = cur_r + 1'b1;
        len_nxt     = len_r + 1'b1;
        finish      = 1'b1;
      end

      S_SHIFT_DN: begin
        if (pend_r) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = pa_r - 1'b1;
          mem_wr.data = mem_rdata;
        end
        if (rem_r != '0) begin
          pend_nxt = 1'b1;
          pa_nxt   = ra_r;
          ra_nxt   = ra_r + 1'b1;
          rem_nxt  = rem_r - 1'b1;
        end else begin
          pend_nxt = 1'b0;
          len_nxt  = len_r - 1'b1;
          finish   = 1'b1;
        end
      end

      S_RD_WAIT: begin
        rd_v   = mem_rdata;
        finish = 1'b1;
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      state_nxt           = S_DONE;
      res_nxt.cursor_pos  = ctb_pkg::POS_W'(cur_nxt);
      res_nxt.text_length = ctb_pkg::POS_W'(len_nxt);
      res_nxt.read_char   = rd_v;
      res_nxt.status      = st_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= '0;
      len_r   <= '0;
      rem_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      len_r   <= len_nxt;
      rem_r   <= rem_nxt;
      pend_r  <= pend_nxt;
    end
    ra_r  <= ra_nxt;
    pa_r  <= pa_nxt;
    ch_r  <= ch_nxt;
    res_r <= res_nxt;
  end

  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= ctb_pkg::CNT_W'(ctb_pkg::CAPACITY))
    else $error("length beyond capacity");

  a_cur_len: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= len_r)
    else $error("cursor beyond length");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE || state_r == S_RD_WAIT) |-> !mem_wr.en)
    else $error("store written outside an edit");

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_take) |=> (res_valid && $stable(res_r)))
    else $error("pending result changed before it was taken");

endmodule

### src/cursor_text_buffer.sv
// ----------------------------------------------------------------------------
// cursor_text_buffer
// Fixed-capacity character store with a cursor and a length.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one request beat (req_type, char_in,
//   read_index). out_valid/out_ready/out_data carry one result beat per
//   request (cursor_pos, text_length, read_char, status).
//   Sequencer states from acceptance to the result in the output register:
//     moves, refused insert, delete at end, read beyond length: S_DONE
//     read: S_RD_WAIT, S_DONE
//     insert: S_SHIFT_UP, S_PUT_CH, S_DONE; delete: S_SHIFT_DN, S_DONE
//   The shift loop moves one entry per cycle through the single read and
//   single write port of the text RAM, so an edit near the start of a full
//   buffer moves about CAPACITY entries. in_ready is high only while the
//   sequencer is idle; one request is in work at a time.
//   Reset (rst_n low, synchronous) clears cursor, length and the output
//   register; the store itself is not cleared, only written entries are read.
//   If the receiver stalls, the result waits in the output register while the
//   next request is taken; a second result then waits in the sequencer until
//   the register drains.
// ----------------------------------------------------------------------------
module cursor_text_buffer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ctb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ctb_pkg::out_item_t out_data
);

  ctb_pkg::mem_wr_t               mem_wr;
  logic [ctb_pkg::ADDR_W-1:0]     mem_raddr;
  logic [ctb_pkg::CHAR_W-1:0]     mem_rdata;

  logic                           res_valid;
  logic                           res_take;
  ctb_pkg::out_item_t             res;

  logic                           out_valid_r;
  ctb_pkg::out_item_t             out_data_r;
  logic                           slot_free;

  // sequencer: cursor/length state and shift loop
  ctb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_data),
    .mem_wr    (mem_wr),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // text store, one write and one registered read per cycle
  ctb_ram #(
    .DEPTH (ctb_pkg::CAPACITY),
    .AW    (ctb_pkg::ADDR_W),
    .DW    (ctb_pkg::CHAR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_wr.en),
    .waddr (mem_wr.addr),
    .wdata (mem_wr.data),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register: loads when empty or when the current beat leaves
  assign slot_free = !out_valid_r || out_ready;
  assign res_take  = res_valid && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= res_valid;
    end
    if (res_take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
